// ===== src/aht_pkg.sv =====
// Shared constants, register codes and divider request/response types
// for the analog hysteresis trigger averager. No dependencies.
package aht_pkg;

    localparam int ADC_W      = 10;   // converter sample
    localparam int MV_W       = 11;   // millivolt values and registers
    localparam int DMV_W      = 14;   // 0.1 mV values
    localparam int SUM_W      = 22;   // running sum of 0.1 mV values
    localparam int CNT_W      = 8;    // wake and sample counters
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int DIV_NUM_W  = SUM_W;              // dividend: sum of samples
    localparam int DIV_DEN_W  = CNT_W;              // divisor: sample count
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    localparam logic [DMV_W-1:0] FULL_SCALE_DMV = DMV_W'(11000);
    localparam logic [ADC_W-1:0] ADC_MAX        = ADC_W'(1023);
    localparam logic [DMV_W-1:0] DMV_PER_MV     = DMV_W'(10);
    localparam logic [DMV_W-1:0] ROUND_HALF     = DMV_W'(5);

    // Scale by 11000 / 1023 as a reciprocal multiply; exact for every sample
    localparam int SCALE_W     = 24;
    localparam int SCALE_SHIFT = 20;
    localparam int PROD_W      = ADC_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_RECIP =
        SCALE_W'(((64'(FULL_SCALE_DMV) << SCALE_SHIFT) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX));

    // Divide by ten as a reciprocal multiply; exact for any 14-bit value
    localparam int TENTH_W     = 16;
    localparam int TENTH_SHIFT = 19;
    localparam int TPROD_W     = DMV_W + TENTH_W;
    localparam logic [TENTH_W-1:0] TENTH_RECIP =
        TENTH_W'(((64'd1 << TENTH_SHIFT) + 64'(DMV_PER_MV) - 64'd1) / 64'(DMV_PER_MV));

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_MV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_MV = 3'd4;

    // Trigger modes
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHANGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RISING  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FALLING = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== src/aht_ifs.sv =====
// Valid/ready channel interfaces for sample items and report items.
// Depends on aht_pkg for the field widths.
interface aht_in_if import aht_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface aht_out_if import aht_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] voltage_mv;
    logic            level_on;

    modport source (output valid, output voltage_mv, output level_on, input ready);
    modport sink   (input valid, input voltage_mv, input level_on, output ready);
endinterface

// ===== src/aht_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on aht_pkg for widths and the request/response structs.
module aht_div import aht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quot;

    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               fits;

    assign trial = {r_rem, r_quot[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= '0;
            r_quot <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_quot <= i_req.num;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits the divisor width
                r_rem  <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_quot <= {r_quot[DIV_NUM_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/analog_hysteresis_trigger_averager_unit.sv =====
// Analog channel averager with hysteresis trigger: sequencer, state and config.
// Depends on aht_pkg, aht_ifs (channel interfaces) and aht_div.
//
// Each item on i_in is one wakeup carrying a 10-bit converter sample. Every
// meas_interval wakeups the sample is scaled to 0.1 mV, summed and counted;
// in a trigger mode a peak or valley reference with hysteresis is tracked.
// A report item leaves on o_out when avg_interval samples have been taken,
// on a trigger in the selected direction, and once after reset. Registers are
// written through i_cfg_we / i_cfg_idx / i_cfg_data while idle; the user ensures this, the block has no check for it.
//
// Timing: scaling and the mV conversions are reciprocal multiplies, one per
// cycle; the average runs on the shared divider. An item with no sample and
// no report passes the check state back to idle; a sample passes the multiply,
// in a trigger mode the two mV conversions and the trigger state, then the
// period check; a report over no samples goes to the finish state directly,
// one with an average through the divider and the rounding state.
// i_in.ready is high only while the sequencer idles. A finished report sits
// in the output register; the next item is taken meanwhile, and a later
// report holds the sequencer until the receiver has taken the earlier one.
// Reset (synchronous, active low) restores the register defaults, clears
// all counters and leaves one report pending for the first wakeup.
module analog_hysteresis_trigger_averager_unit import aht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aht_in_if.sink                i_in,
    aht_out_if.source             o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_V_MV,
        S_REF_MV,
        S_TRIG,
        S_PER,
        S_CHK,
        S_AVG_WAIT,
        S_RND,
        S_FIN
    } t_state;

    // configuration
    logic [CNT_W-1:0]  r_meas;
    logic [CNT_W-1:0]  r_avg;
    logic [MODE_W-1:0] r_mode;
    logic [MV_W-1:0]   r_thr;
    logic [MV_W-1:0]   r_hyst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas <= CNT_W'(1);
            r_avg  <= CNT_W'(1);
            r_mode <= MODE_OFF;
            r_thr  <= '0;
            r_hyst <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAS_INTERVAL: r_meas <= i_cfg_data[CNT_W-1:0];
                CFG_AVG_INTERVAL:  r_avg  <= i_cfg_data[CNT_W-1:0];
                CFG_TRIGGER_MODE:  r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_THRESHOLD_MV:  r_thr  <= i_cfg_data[MV_W-1:0];
                CFG_HYSTERESIS_MV: r_hyst <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // channel state and sequencer
    t_state           r_state;
    logic [CNT_W-1:0] r_wake;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;
    logic [DMV_W-1:0] r_ref;
    logic             r_above;
    logic             r_pending;
    logic [PROD_W-1:0] r_prod;
    logic [DMV_W-1:0] r_v;
    logic [MV_W-1:0]  r_vmv;
    logic [MV_W-1:0]  r_rmv;
    logic [DMV_W-1:0] r_rnd;
    logic [MV_W-1:0]  r_mv;
    t_div_req         r_div_req;
    logic             r_out_valid;
    logic [MV_W-1:0]  r_out_mv;
    logic             r_out_on;

    t_div_rsp         div_rsp;

    logic [CNT_W-1:0]   wake_inc;
    logic [CNT_W-1:0]   count_inc;
    logic               accept;
    logic               take;
    logic [DMV_W-1:0]   v_scaled;
    logic               v_gt_ref;
    logic [DMV_W-1:0]   d10_in;
    logic [TPROD_W-1:0] d10_prod;
    logic [MV_W-1:0]    d10_out;
    logic               rising;
    logic               falling;
    logic               report_trig;
    logic               out_free;
    logic               fin_on;

    aht_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign accept    = i_in.valid && (r_state == S_IDLE);
    assign wake_inc  = (r_wake == '1) ? r_wake : r_wake + 1'b1;
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign take      = wake_inc >= r_meas;

    assign v_scaled = r_prod[SCALE_SHIFT +: DMV_W];
    assign v_gt_ref = v_scaled > r_ref;

    // one shared divide-by-ten multiplier, its operand picked by state
    assign d10_in   = (r_state == S_V_MV)   ? r_v :
                      (r_state == S_REF_MV) ? r_ref : r_rnd;
    assign d10_prod = TPROD_W'(d10_in) * TPROD_W'(TENTH_RECIP);
    assign d10_out  = d10_prod[TENTH_SHIFT +: MV_W];

    // compare in mV
    assign falling = r_above &&
                     (({1'b0, r_vmv} + {1'b0, r_hyst}) < {1'b0, r_rmv});
    assign rising  = !r_above &&
                     ({1'b0, r_vmv} > ({1'b0, r_rmv} + {1'b0, r_hyst}));
    assign report_trig = (r_mode == MODE_CHANGE) ||
                         ((r_mode == MODE_RISING) && rising) ||
                         ((r_mode == MODE_FALLING) && falling);

    assign out_free = !r_out_valid || o_out.ready;
    assign fin_on   = (r_mode == MODE_OFF) ? (r_mv >= r_thr) : r_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wake      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_ref       <= '0;
            r_above     <= 1'b0;
            r_pending   <= 1'b1;
            r_prod      <= '0;
            r_v         <= '0;
            r_vmv       <= '0;
            r_rmv       <= '0;
            r_rnd       <= '0;
            r_mv        <= '0;
            r_div_req   <= '0;
            r_out_valid <= 1'b0;
            r_out_mv    <= '0;
            r_out_on    <= 1'b0;
        end else begin
            // a report leaving in S_FIN reloads the register instead
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (take) begin
                            r_wake  <= '0;
                            r_count <= count_inc;
                            r_prod  <= PROD_W'(i_in.adc_sample) * PROD_W'(SCALE_RECIP);
                            r_state <= S_MUL;
                        end else begin
                            r_wake  <= wake_inc;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_MUL: begin
                    r_v   <= v_scaled;
                    r_sum <= r_sum + SUM_W'(v_scaled);
                    if (r_mode != MODE_OFF) begin
                        // follow the peak or valley
                        if (r_above == v_gt_ref) begin
                            r_ref <= v_scaled;
                        end
                        r_state <= S_V_MV;
                    end else begin
                        r_state <= S_PER;
                    end
                end
                S_V_MV: begin
                    r_vmv   <= d10_out;
                    r_state <= S_REF_MV;
                end
                S_REF_MV: begin
                    r_rmv   <= d10_out;
                    r_state <= S_TRIG;
                end
                S_TRIG: begin
                    if (rising || falling) begin
                        r_above <= !r_above;
                        r_ref   <= r_v;
                        if (report_trig) begin
                            // report the current sample alone
                            r_pending <= 1'b1;
                            r_sum     <= SUM_W'(r_v);
                            r_count   <= CNT_W'(1);
                        end
                    end
                    r_state <= S_PER;
                end
                S_PER: begin
                    if (r_count >= r_avg) begin
                        r_pending <= 1'b1;
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!r_pending) begin
                        r_state <= S_IDLE;
                    end else if (r_count == '0) begin
                        r_mv    <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_div_req <= '{start: 1'b1, num: DIV_NUM_W'(r_sum),
                                       den: DIV_DEN_W'(r_count)};
                        r_state   <= S_AVG_WAIT;
                    end
                end
                S_AVG_WAIT: begin
                    r_div_req.start <= 1'b0;
                    if (div_rsp.done) begin
                        r_rnd   <= div_rsp.quot[DMV_W-1:0] + ROUND_HALF;
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_mv    <= d10_out;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_mv    <= r_mv;
                        r_out_on    <= fin_on;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_wake      <= '0;
                        r_pending   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.voltage_mv = r_out_mv;
    assign o_out.level_on   = r_out_on;

endmodule
